### rtl/i2ceam_pkg.sv
// ----------------------------------------------------------------------------
// i2ceam_pkg
// Types, codes and constants of the I2C EEPROM access master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2ceam_pkg;

  // memory address width sent to the device, 8 to 16
  localparam int unsigned ADDR_BITS = 16;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned TICK_W     = 20;

  localparam logic [7:0] DEV_BYTE_BASE = 8'hA0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_BIT    = 3'd0,
    CFG_START_STOP  = 3'd1,
    CFG_ACK_TIMEOUT = 3'd2,
    CFG_WRITE_CYCLE = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_RANDOM_READ  = 2'd0,
    CMD_BYTE_WRITE   = 2'd1,
    CMD_CURRENT_READ = 2'd2
  } cmd_e;

  // byte steps of a transfer
  localparam logic [2:0] STEP_DEV     = 3'd0;
  localparam logic [2:0] STEP_ADDR_HI = 3'd1;
  localparam logic [2:0] STEP_ADDR_LO = 3'd2;
  localparam logic [2:0] STEP_THIRD   = 3'd3;
  localparam logic [2:0] STEP_RX_RAND = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_SEND_LOW, PH_SEND_HIGH,
    PH_ACK_LOW, PH_ACK_HIGH, PH_RSTART_PREP, PH_RECV_LOW, PH_RECV_HIGH,
    PH_NACK_LOW, PH_NACK_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_WAIT
  } phase_e;

  typedef struct packed {
    logic [7:0]  half_bit_ticks;
    logic [7:0]  start_stop_ticks;
    logic [9:0]  ack_timeout_ticks;
    logic [19:0] write_cycle_ticks;
  } cfg_t;

  typedef struct packed {
    logic        request;
    logic [1:0]  command;
    logic        chip_select_high;
    logic        chip_select_low;
    logic [15:0] mem_address;
    logic [7:0]  write_value;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
  } res_t;

endpackage

`default_nettype wire

### rtl/i2ceam_if.sv
// ----------------------------------------------------------------------------
// i2ceam_if
// Handshake channels of the I2C EEPROM access master: tick items in,
// bus results out, configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2ceam_req_if;
  logic        valid;
  logic        ready;
  logic        request;
  logic [1:0]  command;
  logic        chip_select_high;
  logic        chip_select_low;
  logic [15:0] mem_address;
  logic [7:0]  write_value;
  logic        sda_in;

  modport source (
    output valid, request, command, chip_select_high, chip_select_low,
           mem_address, write_value, sda_in,
    input  ready
  );
  modport sink (
    input  valid, request, command, chip_select_high, chip_select_low,
           mem_address, write_value, sda_in,
    output ready
  );
endinterface

interface i2ceam_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_error;

  modport source (
    output valid, scl_level, sda_pull_low, busy_res, done_res, read_byte, ack_error,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_pull_low, busy_res, done_res, read_byte, ack_error,
    output ready
  );
endinterface

interface i2ceam_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [19:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### rtl/i2c_eeprom_access_master_top.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_master_top
// The result of a tick is registered and shown in the cycle after the
// tick is taken. Throughput: one tick per cycle while results are taken;
// the sequencer advances in the cycle it takes a tick and the result register
// frees itself while being read. Reset: asynchronous, active low; sequencer
// idle, both lines released, timing registers at 2, 4, 250 and 10000 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_access_master_top (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  i2ceam_req_if.sink    req_if,
  i2ceam_res_if.source  res_if,
  i2ceam_cfg_if.sink    cfg_if
);
  import i2ceam_pkg::*;

  cfg_t cfg;
  req_t req;
  res_t res_d;
  res_t res_q;
  logic step_en;

  assign cfg_if.ready = 1'b1;

  i2ceam_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_if.valid && cfg_if.ready),
    .wr_addr_i (cfg_if.addr),
    .wr_data_i (cfg_if.data),
    .cfg_o     (cfg)
  );

  assign req.request          = req_if.request;
  assign req.command          = req_if.command;
  assign req.chip_select_high = req_if.chip_select_high;
  assign req.chip_select_low  = req_if.chip_select_low;
  assign req.mem_address      = req_if.mem_address;
  assign req.write_value      = req_if.write_value;
  assign req.sda_in           = req_if.sda_in;

  assign step_en = req_if.valid && req_if.ready;

  i2ceam_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .req_i     (req),
    .cfg_i     (cfg),
    .res_o     (res_d)
  );

  i2ceam_io_reg u_io (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .res_i       (res_d),
    .out_valid_o (res_if.valid),
    .out_ready_i (res_if.ready),
    .res_o       (res_q)
  );

  assign res_if.scl_level    = res_q.scl_level;
  assign res_if.sda_pull_low = res_q.sda_pull_low;
  assign res_if.busy_res     = res_q.busy_res;
  assign res_if.done_res     = res_q.done_res;
  assign res_if.read_byte    = res_q.read_byte;
  assign res_if.ack_error    = res_q.ack_error;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && res_if.done_res) |-> res_if.busy_res)
    else $error("done shown outside a transfer");

  a_err_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && res_if.ack_error) |-> res_if.done_res)
    else $error("ack error without done");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && !res_if.ready) |-> !req_if.ready)
    else $error("tick taken while result held");

  a_result_follows_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> res_if.valid)
    else $error("accepted tick produced no result");
`endif

endmodule

`default_nettype wire

### rtl/i2ceam_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2ceam_cfg_regs
// Timing registers of the I2C EEPROM access master, one register per write.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ceam_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              wr_en_i,
  input  wire logic [i2ceam_pkg::CFG_IDX_W-1:0]  wr_addr_i,
  input  wire logic [i2ceam_pkg::CFG_DATA_W-1:0] wr_data_i,
  output i2ceam_pkg::cfg_t                       cfg_o
);
  import i2ceam_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks    <= 8'd2;
      cfg_q.start_stop_ticks  <= 8'd4;
      cfg_q.ack_timeout_ticks <= 10'd250;
      cfg_q.write_cycle_ticks <= 20'd10000;
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_addr_i))
        CFG_HALF_BIT:    cfg_q.half_bit_ticks    <= wr_data_i[7:0];
        CFG_START_STOP:  cfg_q.start_stop_ticks  <= wr_data_i[7:0];
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= wr_data_i[9:0];
        CFG_WRITE_CYCLE: cfg_q.write_cycle_ticks <= wr_data_i[19:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/i2ceam_fsm.sv
// ----------------------------------------------------------------------------
// i2ceam_fsm
// Bus sequencer: start, byte shifts, ACK slots, repeated start, read with
// NACK, stop and write wait. Advances one phase step per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ceam_fsm (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_en_i,
  input  i2ceam_pkg::req_t req_i,
  input  i2ceam_pkg::cfg_t cfg_i,
  output i2ceam_pkg::res_t res_o
);
  import i2ceam_pkg::*;

  phase_e            phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [3:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic [2:0]        step_q, step_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [1:0]        cs_q, cs_d;
  logic [15:0]       addr_q, addr_d;
  logic [7:0]        value_q, value_d;
  logic [7:0]        rx_q, rx_d;
  logic              err_q, err_d;

  logic [TICK_W-1:0] tick_inc, len, len_n;
  logic              over;
  logic [3:0]        bit_inc;
  logic [2:0]        next_step;
  logic              next_recv;
  logic [7:0]        next_byte;
  logic              finish;
  logic [7:0]        dev_byte;

  function automatic logic [7:0] byte_for_step(input logic [2:0] step,
                                               input logic [1:0] cmd,
                                               input logic [7:0] dev,
                                               input logic [15:0] addr,
                                               input logic [7:0] value);
    logic [7:0] b;
    case (step)
      STEP_DEV:     b = dev | {7'd0, cmd == CMD_CURRENT_READ};
      STEP_ADDR_HI: b = addr[15:8];
      STEP_ADDR_LO: b = addr[7:0];
      STEP_THIRD:   b = (cmd == CMD_RANDOM_READ) ? (dev | 8'h01) : value;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

  assign dev_byte = DEV_BYTE_BASE | {5'd0, cs_q, 1'b0};
  assign tick_inc = tick_q + 20'd1;
  assign bit_inc  = bit_q + 4'd1;

  // length of the running phase; zero counts as one tick
  always_comb begin
    case (phase_q)
      PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B, PH_STOP_C:
        len = {12'd0, cfg_i.start_stop_ticks};
      PH_ACK_HIGH: len = {10'd0, cfg_i.ack_timeout_ticks};
      PH_WAIT:     len = cfg_i.write_cycle_ticks;
      default:     len = {12'd0, cfg_i.half_bit_ticks};
    endcase
    len_n = (len == '0) ? 20'd1 : len;
    over  = (tick_inc >= len_n);
  end

  // byte step that follows an acknowledged byte
  always_comb begin
    if (step_q == STEP_DEV && cmd_q != CMD_CURRENT_READ) begin
      next_step = (ADDR_BITS > 8) ? STEP_ADDR_HI : STEP_ADDR_LO;
    end else begin
      next_step = step_q + 3'd1;
    end
    next_recv = (cmd_q == CMD_RANDOM_READ && next_step == STEP_RX_RAND) ||
                (cmd_q == CMD_CURRENT_READ && next_step == STEP_ADDR_HI);
    next_byte = byte_for_step(next_step, cmd_q, dev_byte, addr_q, value_q);
  end

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    step_d  = step_q;
    cmd_d   = cmd_q;
    cs_d    = cs_q;
    addr_d  = addr_q;
    value_d = value_q;
    rx_d    = rx_q;
    err_d   = err_q;
    finish  = 1'b0;

    res_o.scl_level    = 1'b1;
    res_o.sda_pull_low = 1'b0;
    case (phase_q)
      PH_START_B:   res_o.sda_pull_low = 1'b1;
      PH_SEND_LOW: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = ~shift_q[7];
      end
      PH_SEND_HIGH: res_o.sda_pull_low = ~shift_q[7];
      PH_ACK_LOW, PH_RSTART_PREP, PH_RECV_LOW, PH_NACK_LOW:
        res_o.scl_level = 1'b0;
      PH_STOP_A: begin
        res_o.scl_level    = 1'b0;
        res_o.sda_pull_low = 1'b1;
      end
      PH_STOP_B:    res_o.sda_pull_low = 1'b1;
      default: ;
    endcase
    res_o.busy_res = (phase_q != PH_IDLE);

    if (phase_q != PH_IDLE && phase_q != PH_ACK_HIGH) begin
      tick_d = over ? '0 : tick_inc;
    end

    case (phase_q)
      PH_IDLE: begin
        if (req_i.request && req_i.command <= CMD_CURRENT_READ) begin
          cmd_d   = req_i.command;
          cs_d    = {req_i.chip_select_high, req_i.chip_select_low};
          addr_d  = req_i.mem_address & ADDR_MASK;
          value_d = req_i.write_value;
          if (req_i.command != CMD_BYTE_WRITE) rx_d = 8'h00;
          err_d   = 1'b0;
          step_d  = STEP_DEV;
          bit_d   = 4'd0;
          tick_d  = '0;
          phase_d = PH_START_A;
        end
      end
      PH_START_A:   if (over) phase_d = PH_START_B;
      PH_START_B: begin
        if (over) begin
          bit_d = 4'd0;
          if ((cmd_q == CMD_RANDOM_READ && step_q == STEP_RX_RAND) ||
              (cmd_q == CMD_CURRENT_READ && step_q == STEP_ADDR_HI)) begin
            shift_d = 8'h00;
            phase_d = PH_RECV_LOW;
          end else begin
            shift_d = byte_for_step(step_q, cmd_q, dev_byte, addr_q, value_q);
            phase_d = PH_SEND_LOW;
          end
        end
      end
      PH_SEND_LOW:  if (over) phase_d = PH_SEND_HIGH;
      PH_SEND_HIGH: begin
        if (over) begin
          shift_d = {shift_q[6:0], 1'b0};
          if (bit_inc >= 4'd8) begin
            bit_d   = 4'd0;
            phase_d = PH_ACK_LOW;
          end else begin
            bit_d   = bit_inc;
            phase_d = PH_SEND_LOW;
          end
        end
      end
      PH_ACK_LOW:   if (over) phase_d = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        if (!req_i.sda_in) begin
          tick_d = '0;
          if (step_q == STEP_ADDR_LO && cmd_q == CMD_RANDOM_READ) begin
            step_d  = STEP_THIRD;
            phase_d = PH_RSTART_PREP;
          end else if (step_q == STEP_THIRD && cmd_q == CMD_BYTE_WRITE) begin
            phase_d = PH_STOP_A;
          end else begin
            step_d = next_step;
            bit_d  = 4'd0;
            if (next_recv) begin
              shift_d = 8'h00;
              phase_d = PH_RECV_LOW;
            end else begin
              shift_d = next_byte;
              phase_d = PH_SEND_LOW;
            end
          end
        end else begin
          tick_d = over ? '0 : tick_inc;
          if (over) begin
            err_d   = 1'b1;
            phase_d = PH_STOP_A;
          end
        end
      end
      PH_RSTART_PREP: if (over) phase_d = PH_START_A;
      PH_RECV_LOW:    if (over) phase_d = PH_RECV_HIGH;
      PH_RECV_HIGH: begin
        if (over) begin
          shift_d = {shift_q[6:0], req_i.sda_in};
          if (bit_inc >= 4'd8) begin
            bit_d   = 4'd0;
            rx_d    = {shift_q[6:0], req_i.sda_in};
            phase_d = PH_NACK_LOW;
          end else begin
            bit_d   = bit_inc;
            phase_d = PH_RECV_LOW;
          end
        end
      end
      PH_NACK_LOW:  if (over) phase_d = PH_NACK_HIGH;
      PH_NACK_HIGH: if (over) phase_d = PH_STOP_A;
      PH_STOP_A:    if (over) phase_d = PH_STOP_B;
      PH_STOP_B:    if (over) phase_d = PH_STOP_C;
      PH_STOP_C: begin
        if (over) begin
          if (cmd_q == CMD_BYTE_WRITE && !err_q && cfg_i.write_cycle_ticks != '0) begin
            phase_d = PH_WAIT;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_WAIT:      if (over) finish = 1'b1;
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase

    if (finish) begin
      phase_d = PH_IDLE;
      tick_d  = '0;
    end

    res_o.done_res  = finish;
    res_o.read_byte = rx_d;
    res_o.ack_error = finish && err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= 4'd0;
      shift_q <= 8'h00;
      step_q  <= STEP_DEV;
      cmd_q   <= CMD_RANDOM_READ;
      cs_q    <= 2'd0;
      addr_q  <= 16'd0;
      value_q <= 8'h00;
      rx_q    <= 8'h00;
      err_q   <= 1'b0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      step_q  <= step_d;
      cmd_q   <= cmd_d;
      cs_q    <= cs_d;
      addr_q  <= addr_d;
      value_q <= value_d;
      rx_q    <= rx_d;
      err_q   <= err_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_tick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (tick_q == '0))
    else $error("tick counter not cleared in idle");

  a_bit_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q < 4'd8)
    else $error("bit index out of range");

  a_stop_after_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && phase_q == PH_ACK_HIGH && req_i.sda_in && over) |=>
      (phase_q == PH_STOP_A && err_q))
    else $error("missing acknowledge did not lead to stop");
`endif

endmodule

`default_nettype wire

### rtl/i2ceam_io_reg.sv
// ----------------------------------------------------------------------------
// i2ceam_io_reg
// Result register between the sequencer and the result channel; takes a
// new tick while the held result is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ceam_io_reg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  i2ceam_pkg::res_t res_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output i2ceam_pkg::res_t res_o
);
  import i2ceam_pkg::*;

  logic valid_q;
  res_t res_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### tb/sv/i2c_eeprom_access_master_top_tb.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_master_top_tb
// Self-checking bench for the I2C EEPROM access master. Every bus tick
// sent in is run through a cycle-exact sequencer model held here, and each
// tick result coming back is compared field by field. A short table of
// transfers (reset timing, extremes, ignored requests, missing
// acknowledges) comes first, then random transfers with zero-length timing,
// answered by a simple device model on sda_in, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module i2c_eeprom_access_master_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2ceam_pkg::*;

  localparam logic [1:0] CMD_RESERVED   = 2'd3;
  localparam logic [2:0] CFG_IDX_UNUSED = 3'd4;
  localparam int         NO_MISS        = -1;
  localparam int         NUM_DIR        = 7;
  localparam int         NUM_RESET_ROWS = 3;
  localparam int         MAX_REPORTS    = 10;
  localparam int         SETTLE_CYCLES  = 4;
  localparam longint     CYCLE_LIMIT    = 2_000_000;

  typedef struct {
    bit          req;
    logic [1:0]  cmd;
    bit          csh;
    bit          csl;
    logic [15:0] addr;
    logic [7:0]  wval;
    logic [7:0]  rdata;
    int          miss_slot;
    bit          poke;
    bit          pinned;
    logic [7:0]  pin_rd;
    bit          pin_err;
  } xfer_row_t;

  logic clk_i;
  logic rst_ni;

  i2ceam_req_if req_ch ();
  i2ceam_res_if res_ch ();
  i2ceam_cfg_if cfg_ch ();

  i2c_eeprom_access_master_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_ch.sink),
    .res_if (res_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  // sequencer model state
  cfg_t        timing;
  phase_e      ph;
  logic [19:0] seq_cnt;
  logic [3:0]  seq_bit;
  logic [7:0]  shift_reg;
  logic [2:0]  seq_step;
  cmd_e        lat_cmd;
  logic [7:0]  lat_dev;
  logic [15:0] lat_addr;
  logic [7:0]  lat_val;
  logic [7:0]  rx_byte;
  bit          seq_err;

  res_t        tick_results_q[$];
  xfer_row_t   dir_rows[NUM_DIR];

  // device model on sda_in
  int          slot_idx;
  int          ack_delay;
  bit          slot_miss;

  bit          calm;
  longint      cycle_cnt;
  int          mismatches;
  int          stray_results;
  int          ticks_sent;
  int          xfer_count[3];
  int          aborts_seen;
  int          settings_run;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit span_elapsed(input logic [19:0] len);
    logic [19:0] lim;
    lim = (len == 20'd0) ? 20'd1 : len;
    seq_cnt = seq_cnt + 20'd1;
    if (seq_cnt >= lim) begin
      seq_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void load_byte_step();
    seq_bit = '0;
    seq_cnt = '0;
    if ((lat_cmd == CMD_RANDOM_READ && seq_step == STEP_RX_RAND) ||
        (lat_cmd == CMD_CURRENT_READ && seq_step == STEP_ADDR_HI)) begin
      shift_reg = '0;
      ph = PH_RECV_LOW;
    end else begin
      case (seq_step)
        STEP_DEV:     shift_reg = lat_dev | {7'd0, lat_cmd == CMD_CURRENT_READ};
        STEP_ADDR_HI: shift_reg = lat_addr[15:8];
        STEP_ADDR_LO: shift_reg = lat_addr[7:0];
        STEP_THIRD:   shift_reg = (lat_cmd == CMD_RANDOM_READ) ? (lat_dev | 8'h01) : lat_val;
        default:      shift_reg = 8'h00;
      endcase
      ph = PH_SEND_LOW;
    end
  endfunction

  // one bus tick through the sequencer: line levels first, then the step
  function automatic res_t predict_bus_tick(input req_t t);
    res_t r;
    bit   finish;
    r = '0;
    r.scl_level = 1'b1;
    finish = 1'b0;
    case (ph)
      PH_START_B:   r.sda_pull_low = 1'b1;
      PH_SEND_LOW: begin
        r.scl_level = 1'b0;
        r.sda_pull_low = ~shift_reg[7];
      end
      PH_SEND_HIGH: r.sda_pull_low = ~shift_reg[7];
      PH_ACK_LOW, PH_RSTART_PREP, PH_RECV_LOW, PH_NACK_LOW: r.scl_level = 1'b0;
      PH_STOP_A: begin
        r.scl_level = 1'b0;
        r.sda_pull_low = 1'b1;
      end
      PH_STOP_B:    r.sda_pull_low = 1'b1;
      default: ;
    endcase
    r.busy_res = (ph != PH_IDLE);

    case (ph)
      PH_IDLE: begin
        if (t.request && t.command <= CMD_CURRENT_READ) begin
          lat_cmd = cmd_e'(t.command);
          lat_dev = DEV_BYTE_BASE | {5'd0, t.chip_select_high, t.chip_select_low, 1'b0};
          lat_addr = t.mem_address & ADDR_MASK;
          lat_val = t.write_value;
          if (t.command != CMD_BYTE_WRITE) rx_byte = '0;
          seq_err = 1'b0;
          seq_step = STEP_DEV;
          seq_bit = '0;
          seq_cnt = '0;
          ph = PH_START_A;
          xfer_count[t.command]++;
        end
      end
      PH_START_A: if (span_elapsed(20'(timing.start_stop_ticks))) ph = PH_START_B;
      PH_START_B: if (span_elapsed(20'(timing.start_stop_ticks))) load_byte_step();
      PH_SEND_LOW: if (span_elapsed(20'(timing.half_bit_ticks))) ph = PH_SEND_HIGH;
      PH_SEND_HIGH: begin
        if (span_elapsed(20'(timing.half_bit_ticks))) begin
          shift_reg = {shift_reg[6:0], 1'b0};
          seq_bit = seq_bit + 4'd1;
          if (seq_bit >= 4'd8) begin
            seq_bit = '0;
            ph = PH_ACK_LOW;
          end else begin
            ph = PH_SEND_LOW;
          end
        end
      end
      PH_ACK_LOW: if (span_elapsed(20'(timing.half_bit_ticks))) ph = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        if (!t.sda_in) begin
          seq_cnt = '0;
          if (seq_step == STEP_DEV && lat_cmd != CMD_CURRENT_READ) begin
            seq_step = (ADDR_BITS > 8) ? STEP_ADDR_HI : STEP_ADDR_LO;
            load_byte_step();
          end else if (seq_step == STEP_ADDR_LO && lat_cmd == CMD_RANDOM_READ) begin
            seq_step = STEP_THIRD;
            ph = PH_RSTART_PREP;
          end else if (seq_step == STEP_THIRD && lat_cmd == CMD_BYTE_WRITE) begin
            ph = PH_STOP_A;
          end else begin
            seq_step = seq_step + 3'd1;
            load_byte_step();
          end
        end else if (span_elapsed(20'(timing.ack_timeout_ticks))) begin
          seq_err = 1'b1;
          ph = PH_STOP_A;
        end
      end
      PH_RSTART_PREP: if (span_elapsed(20'(timing.half_bit_ticks))) ph = PH_START_A;
      PH_RECV_LOW: if (span_elapsed(20'(timing.half_bit_ticks))) ph = PH_RECV_HIGH;
      PH_RECV_HIGH: begin
        if (span_elapsed(20'(timing.half_bit_ticks))) begin
          shift_reg = {shift_reg[6:0], t.sda_in};
          seq_bit = seq_bit + 4'd1;
          if (seq_bit >= 4'd8) begin
            seq_bit = '0;
            rx_byte = shift_reg;
            ph = PH_NACK_LOW;
          end else begin
            ph = PH_RECV_LOW;
          end
        end
      end
      PH_NACK_LOW: if (span_elapsed(20'(timing.half_bit_ticks))) ph = PH_NACK_HIGH;
      PH_NACK_HIGH: if (span_elapsed(20'(timing.half_bit_ticks))) ph = PH_STOP_A;
      PH_STOP_A: if (span_elapsed(20'(timing.start_stop_ticks))) ph = PH_STOP_B;
      PH_STOP_B: if (span_elapsed(20'(timing.start_stop_ticks))) ph = PH_STOP_C;
      PH_STOP_C: begin
        if (span_elapsed(20'(timing.start_stop_ticks))) begin
          if (lat_cmd == CMD_BYTE_WRITE && !seq_err && timing.write_cycle_ticks != 20'd0) begin
            ph = PH_WAIT;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_WAIT: if (span_elapsed(timing.write_cycle_ticks)) finish = 1'b1;
      default: begin
        ph = PH_IDLE;
        seq_cnt = '0;
      end
    endcase

    if (finish) begin
      ph = PH_IDLE;
      seq_cnt = '0;
      r.done_res = 1'b1;
    end
    r.read_byte = rx_byte;
    r.ack_error = r.done_res && seq_err;
    return r;
  endfunction

  // next tick as the bus would present it: the device answers acknowledge
  // slots after a short delay (or never, on the chosen slot) and shifts out
  // the row's data byte; everything the block should ignore is random
  function automatic req_t shape_bus_tick(input xfer_row_t x);
    req_t t;
    int   lim;
    t.request          = x.poke ? 1'($urandom_range(0, 1)) : 1'b0;
    t.command          = 2'($urandom_range(0, 3));
    t.chip_select_high = 1'($urandom_range(0, 1));
    t.chip_select_low  = 1'($urandom_range(0, 1));
    t.mem_address      = 16'($urandom);
    t.write_value      = 8'($urandom);
    t.sda_in           = 1'($urandom_range(0, 1));
    case (ph)
      PH_ACK_HIGH: begin
        if (seq_cnt == 20'd0) begin
          slot_miss = (slot_idx == x.miss_slot);
          slot_idx++;
          lim = (timing.ack_timeout_ticks == 10'd0) ? 1 : int'(timing.ack_timeout_ticks);
          ack_delay = $urandom_range(0, 3);
          if (ack_delay >= lim) ack_delay = lim - 1;
        end
        t.sda_in = slot_miss || (int'(seq_cnt) < ack_delay);
      end
      PH_RECV_HIGH: t.sda_in = x.rdata[7 - int'(seq_bit)];
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_tick(input req_t t);
    if (!calm && $urandom_range(0, 99) < 15) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_ch.valid            <= 1'b1;
    req_ch.request          <= t.request;
    req_ch.command          <= t.command;
    req_ch.chip_select_high <= t.chip_select_high;
    req_ch.chip_select_low  <= t.chip_select_low;
    req_ch.mem_address      <= t.mem_address;
    req_ch.write_value      <= t.write_value;
    req_ch.sda_in           <= t.sda_in;
    do @(posedge clk_i); while (!req_ch.ready);
    tick_results_q.push_back(predict_bus_tick(t));
    ticks_sent++;
  endtask

  // request tick, then ticks until the sequencer is back in idle
  task automatic run_transfer(input xfer_row_t x);
    req_t t;
    res_t last;
    slot_idx = 0;
    t = shape_bus_tick(x);
    t.request          = x.req;
    t.command          = x.cmd;
    t.chip_select_high = x.csh;
    t.chip_select_low  = x.csl;
    t.mem_address      = x.addr;
    t.write_value      = x.wval;
    send_tick(t);
    while (ph != PH_IDLE) send_tick(shape_bus_tick(x));
    if (x.pinned) begin
      last = tick_results_q.pop_back();
      last.scl_level    = 1'b1;
      last.sda_pull_low = 1'b0;
      last.busy_res     = x.req && (x.cmd != CMD_RESERVED);
      last.done_res     = x.req && (x.cmd != CMD_RESERVED);
      last.read_byte    = x.pin_rd;
      last.ack_error    = x.pin_err;
      tick_results_q.push_back(last);
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [19:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_HALF_BIT:    timing.half_bit_ticks    = data[7:0];
      CFG_START_STOP:  timing.start_stop_ticks  = data[7:0];
      CFG_ACK_TIMEOUT: timing.ack_timeout_ticks = data[9:0];
      CFG_WRITE_CYCLE: timing.write_cycle_ticks = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input logic [19:0] hb, input logic [19:0] ss,
                                  input logic [19:0] ack, input logic [19:0] wc,
                                  input int n_xfers, input bit writes_ok,
                                  input bit calm_mode);
    xfer_row_t x;
    wait_drained();
    cfg_write(CFG_HALF_BIT, hb);
    cfg_write(CFG_START_STOP, ss);
    cfg_write(CFG_ACK_TIMEOUT, ack);
    cfg_write(CFG_WRITE_CYCLE, wc);
    settings_run++;
    calm = calm_mode;
    for (int n = 0; n < n_xfers; n++) begin
      // a few ignored ticks in front now and then
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          x = '{default: '0};
          x.req = 1'($urandom_range(0, 1));
          x.cmd = CMD_RESERVED;
          x.miss_slot = NO_MISS;
          run_transfer(x);
        end
      end
      x = '{default: '0};
      x.req = 1'b1;
      if (writes_ok) x.cmd = 2'($urandom_range(0, 2));
      else x.cmd = $urandom_range(0, 1) ? CMD_CURRENT_READ : CMD_RANDOM_READ;
      x.csh = 1'($urandom_range(0, 1));
      x.csl = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) x.addr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else x.addr = 16'($urandom);
      x.wval = 8'($urandom);
      x.rdata = 8'($urandom);
      x.miss_slot = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 4) : NO_MISS;
      x.poke = ($urandom_range(0, 3) == 0);
      run_transfer(x);
    end
    calm = 1'b0;
  endtask

  // result checker
  initial begin
    res_t e;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        if (tick_results_q.size() == 0) begin
          stray_results++;
          if (stray_results + mismatches <= MAX_REPORTS)
            $display("result with nothing expected at cycle %0d", cycle_cnt);
        end else begin
          e = tick_results_q.pop_front();
          if (res_ch.done_res && res_ch.ack_error) aborts_seen++;
          if (res_ch.scl_level !== e.scl_level || res_ch.sda_pull_low !== e.sda_pull_low ||
              res_ch.busy_res !== e.busy_res || res_ch.done_res !== e.done_res ||
              res_ch.read_byte !== e.read_byte || res_ch.ack_error !== e.ack_error) begin
            mismatches++;
            if (stray_results + mismatches <= MAX_REPORTS)
              $display("cycle %0d: exp scl %b sda_low %b busy %b done %b rd %02h err %b, got %s",
                       cycle_cnt, e.scl_level, e.sda_pull_low, e.busy_res, e.done_res,
                       e.read_byte, e.ack_error,
                       $sformatf("scl %b sda_low %b busy %b done %b rd %02h err %b",
                                 res_ch.scl_level, res_ch.sda_pull_low, res_ch.busy_res,
                                 res_ch.done_res, res_ch.read_byte, res_ch.ack_error));
          end
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs that back the block up
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (cycle_cnt == 60 || $urandom_range(0, 3999) == 0) begin
        hold_left = 60 + $urandom_range(0, 20);
        res_ch.ready <= 1'b0;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.request = 1'b0;
    req_ch.command = '0;
    req_ch.chip_select_high = 1'b0;
    req_ch.chip_select_low = 1'b0;
    req_ch.mem_address = '0;
    req_ch.write_value = '0;
    req_ch.sda_in = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;

    timing = '{half_bit_ticks: 8'd2, start_stop_ticks: 8'd4,
               ack_timeout_ticks: 10'd250, write_cycle_ticks: 20'd10000};
    ph = PH_IDLE;
    seq_cnt = '0;
    seq_bit = '0;
    shift_reg = '0;
    seq_step = STEP_DEV;
    lat_cmd = CMD_RANDOM_READ;
    lat_dev = '0;
    lat_addr = '0;
    lat_val = '0;
    rx_byte = '0;
    seq_err = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    stray_results = 0;
    ticks_sent = 0;
    xfer_count = '{0, 0, 0};
    aborts_seen = 0;
    settings_run = 1;

    // req, cmd, csh, csl, addr, wval, rdata, miss slot, poke, pinned, rd, err
    // the first rows run at the reset timing, the rest at short timing
    dir_rows = '{
      '{1'b0, CMD_RESERVED,     1'b0, 1'b0, 16'h0000, 8'h00, 8'h00, NO_MISS, 1'b0, 1'b1, 8'h00, 1'b0},
      '{1'b1, CMD_RESERVED,     1'b1, 1'b1, 16'hFFFF, 8'hFF, 8'h00, NO_MISS, 1'b0, 1'b1, 8'h00, 1'b0},
      '{1'b1, CMD_CURRENT_READ, 1'b1, 1'b0, 16'h0000, 8'h00, 8'h80, NO_MISS, 1'b0, 1'b1, 8'h80, 1'b0},
      '{1'b1, CMD_RANDOM_READ,  1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF, NO_MISS, 1'b0, 1'b1, 8'hFF, 1'b0},
      '{1'b1, CMD_BYTE_WRITE,   1'b1, 1'b0, 16'h5AA5, 8'hA5, 8'h00, NO_MISS, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b1, CMD_RANDOM_READ,  1'b0, 1'b1, 16'h1234, 8'h00, 8'h77, 0,       1'b0, 1'b1, 8'h00, 1'b1},
      '{1'b1, CMD_BYTE_WRITE,   1'b0, 1'b1, 16'h0F0F, 8'hC3, 8'h00, 0,       1'b0, 1'b1, 8'h00, 1'b1}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ignored requests and one read at the reset timing
    for (int i = 0; i < NUM_RESET_ROWS; i++) run_transfer(dir_rows[i]);

    wait_drained();
    cfg_write(CFG_IDX_UNUSED, 20'hFFFFF);
    cfg_write(CFG_HALF_BIT, 20'd1);
    cfg_write(CFG_START_STOP, 20'd1);
    cfg_write(CFG_ACK_TIMEOUT, 20'd3);
    cfg_write(CFG_WRITE_CYCLE, 20'd2);
    settings_run++;

    // first short-timing transfer runs with no idling on either side
    calm = 1'b1;
    run_transfer(dir_rows[NUM_RESET_ROWS]);
    calm = 1'b0;
    for (int i = NUM_RESET_ROWS + 1; i < NUM_DIR; i++) run_transfer(dir_rows[i]);

    // zero lengths (upper data bits must be dropped), random transfers
    run_random_phase(20'hFFF00, 20'h00100, 20'hFFC00, 20'd0, 2, 1'b1, 1'b0);

    wait_drained();

    $display("Ran %0d bus ticks: %0d random reads, %0d byte writes, %0d current reads.",
             ticks_sent, xfer_count[0], xfer_count[1], xfer_count[2]);
    $display("%0d transfers ended on a missing acknowledge; %0d timing settings used.",
             aborts_seen, settings_run);
    if (mismatches == 0 && stray_results == 0 && tick_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d unexpected results", mismatches, stray_results);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
